/* design/csd_pkg.sv */
`timescale 1ns / 1ps
// shared widths, types, register indexes and arithmetic helpers of the cylinder distance unit
package csd_pkg;

   localparam int COORD_W   = 32;
   localparam int UNIT_FB   = 14;
   localparam int COMP_W    = 16;
   localparam int VEC3_W    = 3 * COMP_W;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int EXT_W     = COORD_W + 4;
   localparam int MAG_W     = COORD_W + 2;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int RAD_W     = SQ_W + 2;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int SQ_REM_W  = ROOT_W + 3;
   localparam int WIDE_W    = 80;
   localparam int P_CA_W    = DIFF_W + COMP_W;
   localparam int P_ZA_W    = EXT_W + COMP_W;
   localparam int DIV_STG   = UNIT_FB + 1;
   localparam int SQ_SIDE_W = 4 * EXT_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FALLBACK = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_LEN = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MODE     = 3'd7;

   localparam logic [MAG_W-1:0] LIM_MAG = {MAG_W{1'b1}};
   localparam logic signed [EXT_W-1:0] LIM = {{(EXT_W-MAG_W){1'b0}}, {MAG_W{1'b1}}};
   localparam logic signed [WIDE_W-1:0] RND_HALF =
      {{(WIDE_W-UNIT_FB){1'b0}}, 1'b1, {(UNIT_FB-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] OUT_MAX_W =
      {{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] OUT_MIN_W =
      {{(WIDE_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

   typedef logic [SQ_SIDE_W-1:0] sq_side_type;

   typedef struct packed {
      logic [2:0][EXT_W-1:0]   rv;
      logic signed [EXT_W-1:0] z;
   } geo_side_type;

   typedef struct packed {
      logic signed [EXT_W-1:0] dr;
      logic signed [EXT_W-1:0] dz;
      logic                    interior;
   } div_side_type;

   typedef struct packed {
      logic [2:0][COMP_W-1:0] er;
      div_side_type           ds;
   } dist_side_type;

   localparam int DIST_SIDE_W = $bits(dist_side_type);

   function automatic logic signed [COMP_W-1:0] get_comp(input logic [VEC3_W-1:0] v,
                                                          input int i);
      get_comp = v[(2-i)*COMP_W +: COMP_W];
   endfunction

   function automatic logic signed [EXT_W-1:0] sat_ext(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] lim_w;
      lim_w = WIDE_W'(LIM);
      if (x > lim_w) begin
         sat_ext = LIM;
      end else if (x < -lim_w) begin
         sat_ext = -LIM;
      end else begin
         sat_ext = x[EXT_W-1:0];
      end
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_out(input logic signed [WIDE_W-1:0] x);
      if (x > OUT_MAX_W) begin
         sat_out = OUT_MAX_W[COORD_W-1:0];
      end else if (x < OUT_MIN_W) begin
         sat_out = OUT_MIN_W[COORD_W-1:0];
      end else begin
         sat_out = x[COORD_W-1:0];
      end
   endfunction

   // round to nearest at the unit fraction, ties upward
   function automatic logic signed [WIDE_W-1:0] rnd_shift(input logic signed [WIDE_W-1:0] x);
      rnd_shift = (x + RND_HALF) >>> UNIT_FB;
   endfunction

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [EXT_W-1:0] x);
      logic signed [EXT_W-1:0] t;
      t = (x < 0) ? -x : x;
      mag_of = t[MAG_W-1:0];
   endfunction

endpackage

/* design/csd_proj.sv */
`timescale 1ns / 1ps
// axial projection, radial remainder and sum of squares, seven register stages
module csd_proj import csd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [2:0][COORD_W-1:0]      pos,
   input  logic [2:0][COORD_W-1:0]      center,
   input  logic [VEC3_W-1:0]            axis,
   output logic                         out_valid,
   output logic [RAD_W-1:0]             sum_sq,
   output geo_side_type                 side
);

   logic [6:0] v_ff;

   logic signed [COMP_W-1:0] ax     [3];
   logic signed [DIFF_W-1:0] c1_in  [3];
   logic signed [DIFF_W-1:0] c1_ff  [3];
   logic signed [P_CA_W-1:0] pa_in  [3];
   logic signed [P_CA_W-1:0] pa_ff  [3];
   logic signed [DIFF_W-1:0] c2_ff  [3];
   logic signed [EXT_W-1:0]  z3_in;
   logic signed [EXT_W-1:0]  z3_ff;
   logic signed [DIFF_W-1:0] c3_ff  [3];
   logic signed [P_ZA_W-1:0] za_in  [3];
   logic signed [P_ZA_W-1:0] za_ff  [3];
   logic signed [DIFF_W-1:0] c4_ff  [3];
   logic signed [EXT_W-1:0]  z4_ff;
   logic signed [EXT_W-1:0]  rv5_in [3];
   logic signed [EXT_W-1:0]  rv5_ff [3];
   logic signed [EXT_W-1:0]  z5_ff;
   logic [SQ_W-1:0]          sq6_in [3];
   logic [SQ_W-1:0]          sq6_ff [3];
   logic signed [EXT_W-1:0]  rv6_ff [3];
   logic signed [EXT_W-1:0]  z6_ff;
   logic [RAD_W-1:0]         s7_in;
   logic [RAD_W-1:0]         s7_ff;
   geo_side_type             side7_ff;
   logic signed [WIDE_W-1:0] dot_w;
   logic [MAG_W-1:0]         mag6   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ax[i]     = get_comp(axis, i);
         c1_in[i]  = DIFF_W'($signed(pos[i])) - DIFF_W'($signed(center[i]));
         pa_in[i]  = P_CA_W'(c1_ff[i]) * P_CA_W'(ax[i]);
         za_in[i]  = P_ZA_W'(z3_ff) * P_ZA_W'(ax[i]);
         rv5_in[i] = sat_ext(WIDE_W'(c4_ff[i]) - rnd_shift(WIDE_W'(za_ff[i])));
         mag6[i]   = mag_of(rv5_ff[i]);
         sq6_in[i] = SQ_W'(mag6[i]) * SQ_W'(mag6[i]);
      end
      dot_w = WIDE_W'(pa_ff[0]) + WIDE_W'(pa_ff[1]) + WIDE_W'(pa_ff[2]);
      z3_in = sat_ext(rnd_shift(dot_w));
      s7_in = RAD_W'(sq6_ff[0]) + RAD_W'(sq6_ff[1]) + RAD_W'(sq6_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c1_ff[i]  <= c1_in[i];
            pa_ff[i]  <= pa_in[i];
            c2_ff[i]  <= c1_ff[i];
            c3_ff[i]  <= c2_ff[i];
            za_ff[i]  <= za_in[i];
            c4_ff[i]  <= c3_ff[i];
            rv5_ff[i] <= rv5_in[i];
            sq6_ff[i] <= sq6_in[i];
            rv6_ff[i] <= rv5_ff[i];
            side7_ff.rv[i] <= rv6_ff[i];
         end
         z3_ff       <= z3_in;
         z4_ff       <= z3_ff;
         z5_ff       <= z4_ff;
         z6_ff       <= z5_ff;
         side7_ff.z  <= z6_ff;
         s7_ff       <= s7_in;
      end
   end

   assign out_valid = v_ff[6];
   assign sum_sq    = s7_ff;
   assign side      = side7_ff;

endmodule

/* design/csd_sqrt.sv */
`timescale 1ns / 1ps
// pipelined floor square root, one root bit per register stage
module csd_sqrt import csd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  radicand,
   input  sq_side_type       side_in,
   output logic              out_valid,
   output logic [ROOT_W-1:0] root,
   output sq_side_type       side_out
);

   logic                v_ff    [ROOT_W];
   logic [SQ_REM_W-1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [RAD_W-1:0]    rad_ff  [ROOT_W];
   sq_side_type         side_ff [ROOT_W];

   logic                v_p     [ROOT_W];
   logic [SQ_REM_W-1:0] rem_p   [ROOT_W];
   logic [ROOT_W-1:0]   root_p  [ROOT_W];
   logic [RAD_W-1:0]    rad_p   [ROOT_W];
   sq_side_type         side_p  [ROOT_W];
   logic [SQ_REM_W-1:0] rem_sh  [ROOT_W];
   logic [SQ_REM_W-1:0] trial   [ROOT_W];
   logic                ge      [ROOT_W];
   logic [SQ_REM_W-1:0] rem_in  [ROOT_W];
   logic [ROOT_W-1:0]   root_in [ROOT_W];

   always_comb begin
      for (int k = 0; k < ROOT_W; k++) begin
         if (k == 0) begin
            v_p[k]    = in_valid;
            rem_p[k]  = '0;
            root_p[k] = '0;
            rad_p[k]  = radicand;
            side_p[k] = side_in;
         end else begin
            v_p[k]    = v_ff[k-1];
            rem_p[k]  = rem_ff[k-1];
            root_p[k] = root_ff[k-1];
            rad_p[k]  = rad_ff[k-1];
            side_p[k] = side_ff[k-1];
         end
         rem_sh[k]  = {rem_p[k][SQ_REM_W-3:0], rad_p[k][RAD_W-1 -: 2]};
         trial[k]   = SQ_REM_W'({root_p[k], 2'b01});
         ge[k]      = rem_sh[k] >= trial[k];
         rem_in[k]  = ge[k] ? rem_sh[k] - trial[k] : rem_sh[k];
         root_in[k] = {root_p[k][ROOT_W-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_W; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            v_ff[k] <= v_p[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= {rad_p[k][RAD_W-3:0], 2'b00};
            side_ff[k] <= side_p[k];
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign side_out  = side_ff[ROOT_W-1];

endmodule

/* design/csd_div.sv */
`timescale 1ns / 1ps
// three-lane pipelined restoring divider for the radial unit vector
module csd_div import csd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [2:0][EXT_W-1:0]  num,
   input  logic [MAG_W-1:0]       den,
   input  logic [VEC3_W-1:0]      fallback,
   input  div_side_type           side_in,
   output logic                   out_valid,
   output logic [2:0][COMP_W-1:0] quot,
   output div_side_type           side_out
);

   logic               v_ff    [DIV_STG];
   logic [MAG_W-1:0]   rem_ff  [DIV_STG][3];
   logic [UNIT_FB:0]   q_ff    [DIV_STG][3];
   logic               neg_ff  [DIV_STG][3];
   logic [MAG_W-1:0]   d_ff    [DIV_STG];
   div_side_type       side_ff [DIV_STG];

   logic [MAG_W-1:0]   rem_in  [DIV_STG][3];
   logic [UNIT_FB:0]   q_in    [DIV_STG][3];
   logic [MAG_W:0]     sh      [DIV_STG][3];
   logic               ge      [DIV_STG][3];
   logic [MAG_W-1:0]   mag0    [3];

   logic                   fin_v_ff;
   logic [2:0][COMP_W-1:0] fin_q_ff;
   div_side_type           fin_side_ff;
   logic [2:0][COMP_W-1:0] fin_q_in;
   logic [UNIT_FB:0]       q_rnd   [3];
   logic signed [COMP_W-1:0] q_ext [3];
   logic                   rnd_up  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag0[i] = mag_of($signed(num[i]));
      end
      for (int k = 0; k < DIV_STG; k++) begin
         for (int i = 0; i < 3; i++) begin
            if (k == 0) begin
               sh[k][i]   = {1'b0, mag0[i]};
               ge[k][i]   = sh[k][i] >= {1'b0, den};
               rem_in[k][i] = MAG_W'(ge[k][i] ? sh[k][i] - {1'b0, den} : sh[k][i]);
               q_in[k][i] = (UNIT_FB+1)'(ge[k][i]);
            end else begin
               sh[k][i]   = {rem_ff[k-1][i], 1'b0};
               ge[k][i]   = sh[k][i] >= {1'b0, d_ff[k-1]};
               rem_in[k][i] = MAG_W'(ge[k][i] ? sh[k][i] - {1'b0, d_ff[k-1]} : sh[k][i]);
               q_in[k][i] = {q_ff[k-1][i][UNIT_FB-1:0], ge[k][i]};
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         rnd_up[i] = {rem_ff[DIV_STG-1][i], 1'b0} >= {1'b0, d_ff[DIV_STG-1]};
         q_rnd[i]  = q_ff[DIV_STG-1][i] + (UNIT_FB+1)'(rnd_up[i]);
         q_ext[i]  = COMP_W'(q_rnd[i]);
         if (d_ff[DIV_STG-1] == '0) begin
            fin_q_in[i] = get_comp(fallback, i);
         end else if (neg_ff[DIV_STG-1][i]) begin
            fin_q_in[i] = -q_ext[i];
         end else begin
            fin_q_in[i] = q_ext[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STG; k++) begin
            v_ff[k] <= 1'b0;
         end
         fin_v_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < DIV_STG; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         fin_v_ff <= v_ff[DIV_STG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STG; k++) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[k][i] <= rem_in[k][i];
               q_ff[k][i]   <= q_in[k][i];
            end
         end
         for (int i = 0; i < 3; i++) begin
            neg_ff[0][i] <= num[i][EXT_W-1];
         end
         d_ff[0]    <= den;
         side_ff[0] <= side_in;
         for (int k = 1; k < DIV_STG; k++) begin
            for (int i = 0; i < 3; i++) begin
               neg_ff[k][i] <= neg_ff[k-1][i];
            end
            d_ff[k]    <= d_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
         fin_q_ff    <= fin_q_in;
         fin_side_ff <= side_ff[DIV_STG-1];
      end
   end

   assign out_valid = fin_v_ff;
   assign quot      = fin_q_ff;
   assign side_out  = fin_side_ff;

endmodule

/* design/cylinder_signed_distance_unit.sv */
`timescale 1ns / 1ps
// top level of the cylinder signed distance unit: config registers, feature select, output
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata: pos_x, pos_y, pos_z
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: distance, vec_x, vec_y, vec_z
//  csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// one point per cycle while the output is not stalled; the path is made of the two 35-stage square root
// pipelines, the 16-stage divider and the projection and product stages around them
// all stages advance together; the pipeline holds whole while rsp_tvalid waits unaccepted
// synchronous reset clears valid bits and loads the register reset values
// csr writes are taken every cycle
module cylinder_signed_distance_unit import csd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [3*COORD_W-1:0]    req_tdata,   // pos_x, pos_y, pos_z
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [4*COORD_W-1:0]    rsp_tdata,   // distance, vec_x, vec_y, vec_z
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [2:0][COORD_W-1:0] center_ff;
   logic [VEC3_W-1:0]       axis_ff;
   logic [VEC3_W-1:0]       fall_ff;
   logic [COORD_W-2:0]      radius_ff;
   logic [COORD_W-2:0]      half_ff;
   logic [1:0]              mode_ff;

   logic en;

   logic              p_valid;
   logic [RAD_W-1:0]  p_sum;
   geo_side_type      p_side;
   logic              s1_valid;
   logic [ROOT_W-1:0] s1_root;
   sq_side_type       s1_side;
   geo_side_type      g1;

   logic signed [EXT_W-1:0] h_ext, r_ext, hmr_ext;
   logic signed [COMP_W-1:0] ax [3];

   logic                    f0_v_ff;
   logic [MAG_W-1:0]        f0_r_in, f0_r_ff;
   logic [MAG_W-1:0]        f0_az;
   logic signed [EXT_W-1:0] f0_az_ext;
   logic                    f0_zle_ff;
   logic signed [EXT_W-1:0] f0_dz_raw_ff, f0_dr_raw_ff, f0_t_ff;
   logic [2:0][EXT_W-1:0]   f0_rv_ff;

   logic                    f1_v_ff;
   logic signed [EXT_W-1:0] f1_dr_in, f1_dz_in, f1_dr_ff, f1_dz_ff;
   logic                    f1_inside_in, f1_inside_ff;
   logic [2:0][EXT_W-1:0]   f1_rv_ff;
   logic [MAG_W-1:0]        f1_r_ff;
   logic signed [EXT_W-1:0] f1_r_ext;
   logic                    ge_h, ge_r, ge_hr, lt_t;
   div_side_type            f1_side;

   logic                   d_valid;
   logic [2:0][COMP_W-1:0] d_quot;
   div_side_type           d_side;

   logic          q1_v_ff;
   logic [SQ_W-1:0] q1_sqr_ff, q1_sqz_ff;
   dist_side_type q1_side_ff;
   logic          q2_v_ff;
   logic [RAD_W-1:0] q2_sum_ff;
   dist_side_type q2_side_ff;

   logic              s2_valid;
   logic [ROOT_W-1:0] s2_root;
   sq_side_type       s2_side;
   dist_side_type     e;

   logic                     m1_v_ff;
   logic signed [COORD_W-1:0] m1_dist_in, m1_dist_ff;
   logic signed [WIDE_W-1:0] dist_w;
   logic signed [P_ZA_W-1:0] pr_in [3];
   logic signed [P_ZA_W-1:0] pr_ff [3];
   logic signed [P_ZA_W-1:0] pz_in [3];
   logic signed [P_ZA_W-1:0] pz_ff [3];

   logic                      out_v_ff;
   logic signed [COORD_W-1:0] out_dist_ff;
   logic [2:0][COORD_W-1:0]   out_vec_in, out_vec_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         axis_ff   <= VEC3_W'(16384);
         fall_ff   <= VEC3_W'(1073741824);
         radius_ff <= (COORD_W-1)'(65536);
         half_ff   <= (COORD_W-1)'(65536);
         mode_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CENTER_X: center_ff[0] <= csr_wdata[COORD_W-1:0];
            REG_CENTER_Y: center_ff[1] <= csr_wdata[COORD_W-1:0];
            REG_CENTER_Z: center_ff[2] <= csr_wdata[COORD_W-1:0];
            REG_AXIS:     axis_ff      <= csr_wdata[VEC3_W-1:0];
            REG_FALLBACK: fall_ff      <= csr_wdata[VEC3_W-1:0];
            REG_RADIUS:   radius_ff    <= csr_wdata[COORD_W-2:0];
            REG_HALF_LEN: half_ff      <= csr_wdata[COORD_W-2:0];
            REG_MODE:     mode_ff      <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   csd_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .pos       (req_tdata),
      .center    (center_ff),
      .axis      (axis_ff),
      .out_valid (p_valid),
      .sum_sq    (p_sum),
      .side      (p_side)
   );

   csd_sqrt u_sqrt_r (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .radicand  (p_sum),
      .side_in   (p_side),
      .out_valid (s1_valid),
      .root      (s1_root),
      .side_out  (s1_side)
   );

   // feature selection
   always_comb begin
      g1        = s1_side;
      h_ext     = $signed({{(EXT_W-COORD_W+1){1'b0}}, half_ff});
      r_ext     = $signed({{(EXT_W-COORD_W+1){1'b0}}, radius_ff});
      hmr_ext   = h_ext - r_ext;
      f0_r_in   = (s1_root > {1'b0, LIM_MAG}) ? LIM_MAG : s1_root[MAG_W-1:0];
      f0_az     = mag_of(g1.z);
      f0_az_ext = $signed({{(EXT_W-MAG_W){1'b0}}, f0_az});
      for (int i = 0; i < 3; i++) begin
         ax[i] = get_comp(axis_ff, i);
      end

      f1_r_ext = $signed({{(EXT_W-MAG_W){1'b0}}, f0_r_ff});
      ge_h     = f0_dz_raw_ff <= 0;
      ge_r     = f0_dr_raw_ff <= 0;
      ge_hr    = f0_t_ff >= 0;
      lt_t     = f1_r_ext < f0_t_ff;
      if (ge_h || ge_r) begin
         f1_inside_in = 1'b0;
         if (!mode_ff[0] && ge_h && !ge_r) begin
            f1_dr_in = '0;
            f1_dz_in = f0_dz_raw_ff;
         end else if (ge_h) begin
            f1_dr_in = f0_dr_raw_ff;
            f1_dz_in = f0_dz_raw_ff;
         end else begin
            f1_dr_in = f0_dr_raw_ff;
            f1_dz_in = '0;
         end
      end else begin
         f1_inside_in = 1'b1;
         if (!mode_ff[0] && ge_hr && lt_t) begin
            f1_dr_in = '0;
            f1_dz_in = f0_dz_raw_ff;
         end else begin
            f1_dr_in = f0_dr_raw_ff;
            f1_dz_in = '0;
         end
      end
      if (f0_zle_ff) begin
         f1_dz_in = -f1_dz_in;
      end
      f1_side.dr       = f1_dr_ff;
      f1_side.dz       = f1_dz_ff;
      f1_side.interior = f1_inside_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_v_ff  <= 1'b0;
         f1_v_ff  <= 1'b0;
         q1_v_ff  <= 1'b0;
         q2_v_ff  <= 1'b0;
         m1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         f0_v_ff  <= s1_valid;
         f1_v_ff  <= f0_v_ff;
         q1_v_ff  <= d_valid;
         q2_v_ff  <= q1_v_ff;
         m1_v_ff  <= s2_valid;
         out_v_ff <= m1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f0_r_ff      <= f0_r_in;
         f0_zle_ff    <= g1.z[EXT_W-1] || (g1.z == '0);
         f0_dz_raw_ff <= h_ext - f0_az_ext;
         f0_dr_raw_ff <= r_ext - $signed({{(EXT_W-MAG_W){1'b0}}, f0_r_in});
         f0_t_ff      <= f0_az_ext - hmr_ext;
         f0_rv_ff     <= g1.rv;
         f1_dr_ff     <= f1_dr_in;
         f1_dz_ff     <= f1_dz_in;
         f1_inside_ff <= f1_inside_in;
         f1_rv_ff     <= f0_rv_ff;
         f1_r_ff      <= f0_r_ff;
      end
   end

   csd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f1_v_ff),
      .num       (f1_rv_ff),
      .den       (f1_r_ff),
      .fallback  (fall_ff),
      .side_in   (f1_side),
      .out_valid (d_valid),
      .quot      (d_quot),
      .side_out  (d_side)
   );

   // distance radicand
   always_ff @(posedge clock) begin
      if (en) begin
         q1_sqr_ff     <= SQ_W'(mag_of(d_side.dr)) * SQ_W'(mag_of(d_side.dr));
         q1_sqz_ff     <= SQ_W'(mag_of(d_side.dz)) * SQ_W'(mag_of(d_side.dz));
         q1_side_ff.er <= d_quot;
         q1_side_ff.ds <= d_side;
         q2_sum_ff     <= RAD_W'(q1_sqr_ff) + RAD_W'(q1_sqz_ff);
         q2_side_ff    <= q1_side_ff;
      end
   end

   csd_sqrt u_sqrt_d (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (q2_v_ff),
      .radicand  (q2_sum_ff),
      .side_in   ({{(SQ_SIDE_W-DIST_SIDE_W){1'b0}}, q2_side_ff}),
      .out_valid (s2_valid),
      .root      (s2_root),
      .side_out  (s2_side)
   );

   // output products and saturation
   always_comb begin
      e      = s2_side[DIST_SIDE_W-1:0];
      dist_w = $signed({{(WIDE_W-ROOT_W){1'b0}}, s2_root});
      if (e.ds.interior ^ mode_ff[1]) begin
         dist_w = -dist_w;
      end
      m1_dist_in = sat_out(dist_w);
      for (int i = 0; i < 3; i++) begin
         pr_in[i] = P_ZA_W'(e.ds.dr) * P_ZA_W'($signed(e.er[i]));
         pz_in[i] = P_ZA_W'(e.ds.dz) * P_ZA_W'(ax[i]);
         out_vec_in[i] = sat_out(-rnd_shift(WIDE_W'(pr_ff[i]))
                                 - rnd_shift(WIDE_W'(pz_ff[i])));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_dist_ff  <= m1_dist_in;
         for (int i = 0; i < 3; i++) begin
            pr_ff[i] <= pr_in[i];
            pz_ff[i] <= pz_in[i];
         end
         out_dist_ff <= m1_dist_ff;
         out_vec_ff  <= out_vec_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_vec_ff, out_dist_ff};

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (f1_v_ff && !en) |=> (f1_v_ff && $stable(f1_dr_ff) && $stable(f1_dz_ff)))
      else $error("feature stage changed during stall");

   a_inside_one_part: assert property (@(posedge clock) disable iff (reset)
      (f1_v_ff && f1_inside_ff) |-> (f1_dr_ff == '0 || f1_dz_ff == '0))
      else $error("inside point with both radial and axial offsets");

endmodule

/* sim/csd_checker.sv */
`timescale 1ns / 1ps
// checker of the cylinder distance unit: tracks csr writes, predicts each result and compares
module csd_checker import csd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [3*COORD_W-1:0]  req_tdata,   // pos_x, pos_y, pos_z
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [4*COORD_W-1:0]  rsp_tdata,   // distance, vec_x, vec_y, vec_z
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    failures,
   output int                    outstanding,
   output int                    results_seen
);

   localparam longint LIM_C = 64'sh3_FFFF_FFFF;
   localparam longint HALF_C = 64'sd8192;

   typedef struct {
      logic signed [COORD_W-1:0] distance;
      logic signed [COORD_W-1:0] vec[3];
   } dist_result_type;

   longint          cen[3];
   logic [47:0]     axis_r, fall_r;
   longint          rad_r, half_r;
   logic [1:0]      mode_r;
   dist_result_type expected_dists[$];

   function automatic longint clip(longint v);
      clip = (v > LIM_C) ? LIM_C : (v < -LIM_C) ? -LIM_C : v;
   endfunction

   function automatic logic signed [COORD_W-1:0] clip_out(longint v);
      if (v > 64'sd2147483647) clip_out = 32'h7FFF_FFFF;
      else if (v < -64'sd2147483648) clip_out = 32'h8000_0000;
      else clip_out = v[31:0];
   endfunction

   function automatic longint unit_mul(longint v, longint a);
      longint vh;
      vh = v >>> UNIT_FB;
      unit_mul = vh * a + (((v - (vh <<< UNIT_FB)) * a + HALF_C) >>> UNIT_FB);
   endfunction

   function automatic logic [127:0] square(longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      square = m * m;
   endfunction

   function automatic longint root_floor(logic [127:0] s);
      logic [127:0] res, cand;
      res = '0;
      for (int b = 55; b >= 0; b--) begin
         cand = res | (128'd1 << b);
         if (cand * cand <= s) res = cand;
      end
      root_floor = longint'(res[63:0]);
   endfunction

   function automatic longint unit_ratio(longint num, longint den);
      logic [63:0] rem, d, q;
      rem = (num < 0) ? -num : num;
      d = den;
      q = 0;
      if (rem >= d) begin
         q = 1;
         rem = rem - d;
      end
      for (int k = 0; k < UNIT_FB; k++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= d) begin
            q = q + 1;
            rem = rem - d;
         end
      end
      if (2 * rem >= d) q = q + 1;
      unit_ratio = (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic dist_result_type cylinder_distance_of(logic [3*COORD_W-1:0] pos);
      dist_result_type res;
      longint c[3], ax[3], rv[3], er[3];
      longint vh, hacc, lacc, z, r, az, dr, dz, side, d, v;
      logic [127:0] s;
      logic closed;
      closed = !mode_r[0];
      hacc = 0;
      lacc = HALF_C;
      s = '0;
      for (int i = 0; i < 3; i++) begin
         c[i] = longint'($signed(pos[i*COORD_W +: COORD_W])) - cen[i];
         ax[i] = longint'($signed(axis_r[(2-i)*16 +: 16]));
         vh = c[i] >>> UNIT_FB;
         hacc += vh * ax[i];
         lacc += (c[i] - (vh <<< UNIT_FB)) * ax[i];
      end
      z = clip(hacc + (lacc >>> UNIT_FB));
      for (int i = 0; i < 3; i++) begin
         rv[i] = clip(c[i] - unit_mul(z, ax[i]));
         s += square(rv[i]);
      end
      r = clip(root_floor(s));
      for (int i = 0; i < 3; i++)
         er[i] = (r == 0) ? longint'($signed(fall_r[(2-i)*16 +: 16])) : unit_ratio(rv[i], r);
      az = (z < 0) ? -z : z;
      if (az >= half_r || r >= rad_r) begin
         side = 1;
         if (closed && az >= half_r && r < rad_r) begin
            dr = 0;
            dz = half_r - az;
         end else if (az >= half_r) begin
            dr = rad_r - r;
            dz = half_r - az;
         end else begin
            dr = rad_r - r;
            dz = 0;
         end
      end else begin
         side = -1;
         if (closed && az >= half_r - rad_r && r < az - (half_r - rad_r)) begin
            dr = 0;
            dz = half_r - az;
         end else begin
            dr = rad_r - r;
            dz = 0;
         end
      end
      if (z <= 0) dz = -dz;
      d = root_floor(square(dr) + square(dz)) * side;
      if (mode_r[1]) d = -d;
      res.distance = clip_out(d);
      for (int i = 0; i < 3; i++) begin
         v = -unit_mul(dr, er[i]) - unit_mul(dz, ax[i]);
         res.vec[i] = clip_out(v);
      end
      return res;
   endfunction

   assign outstanding = expected_dists.size();

   always @(posedge clock) begin
      dist_result_type want;
      logic signed [COORD_W-1:0] got;
      int errs;
      errs = 0;
      if (reset) begin
         cen = '{0, 0, 0};
         axis_r <= 48'd16384;
         fall_r <= 48'd1073741824;
         rad_r <= 65536;
         half_r <= 65536;
         mode_r <= '0;
         failures <= 0;
         results_seen <= 0;
         expected_dists.delete();
      end else begin
         if (req_tvalid && req_tready) expected_dists.push_back(cylinder_distance_of(req_tdata));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CENTER_X: cen[0] = longint'($signed(csr_wdata[COORD_W-1:0]));
               REG_CENTER_Y: cen[1] = longint'($signed(csr_wdata[COORD_W-1:0]));
               REG_CENTER_Z: cen[2] = longint'($signed(csr_wdata[COORD_W-1:0]));
               REG_AXIS:     axis_r <= csr_wdata;
               REG_FALLBACK: fall_r <= csr_wdata;
               REG_RADIUS:   rad_r <= longint'(csr_wdata[COORD_W-2:0]);
               REG_HALF_LEN: half_r <= longint'(csr_wdata[COORD_W-2:0]);
               REG_MODE:     mode_r <= csr_wdata[1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (expected_dists.size() == 0) begin
               $error("unexpected result transaction: %h", rsp_tdata);
               errs++;
            end else begin
               want = expected_dists.pop_front();
               got = rsp_tdata[0 +: COORD_W];
               if (got !== want.distance) begin
                  $error("distance mismatch: expected %0d actual %0d", want.distance, got);
                  errs++;
               end
               for (int i = 0; i < 3; i++) begin
                  got = rsp_tdata[(i+1)*COORD_W +: COORD_W];
                  if (got !== want.vec[i]) begin
                     $error("vec_%s mismatch: expected %0d actual %0d",
                            (i == 0) ? "x" : (i == 1) ? "y" : "z", want.vec[i], got);
                     errs++;
                  end
               end
            end
            failures <= failures + errs;
         end
      end
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// testbench top of the cylinder distance unit: clock, reset, stimulus and verdict
module tb;
   import csd_pkg::*;

   localparam int LAST_PHASE = 10;
   localparam int RAND_PER_PHASE = 100;
   localparam int CYCLE_LIMIT = 300000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid, req_tready;
   logic [3*COORD_W-1:0]  req_tdata;   // pos_x, pos_y, pos_z
   logic                  rsp_tvalid, rsp_tready;
   logic [4*COORD_W-1:0]  rsp_tdata;   // distance, vec_x, vec_y, vec_z
   logic                  csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    failures, outstanding, results_seen;

   int          cycles = 0;
   int          points_sent = 0;
   int          csr_writes = 0;
   int          stall_left = 0;
   logic        idling = 1'b1;
   longint      ctr[3], axc[3], rad, half;

   cylinder_signed_distance_unit dut (.*);

   csd_checker checker_i (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // csr_valid stays high across back to back writes; the caller drops it
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      logic rdy;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(negedge clock);
         rdy = csr_ready;
         @(posedge clock);
      end while (!rdy);
      csr_writes++;
      case (idx)
         REG_CENTER_X: ctr[0] = longint'($signed(data[31:0]));
         REG_CENTER_Y: ctr[1] = longint'($signed(data[31:0]));
         REG_CENTER_Z: ctr[2] = longint'($signed(data[31:0]));
         REG_AXIS:
            for (int i = 0; i < 3; i++) axc[i] = longint'($signed(data[(2-i)*16 +: 16]));
         REG_RADIUS:   rad = longint'(data[30:0]);
         REG_HALF_LEN: half = longint'(data[30:0]);
         default: ;
      endcase
   endtask

   task automatic send_point(longint x, longint y, longint z);
      logic rdy;
      if (idling && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z[31:0], y[31:0], x[31:0]};
      do begin
         @(negedge clock);
         rdy = req_tready;
         @(posedge clock);
      end while (!rdy);
      points_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic longint span_rand(longint span);
      logic [63:0] r;
      r = {$urandom, $urandom} >> 1;
      return longint'(r % (2 * span + 1)) - span;
   endfunction

   function automatic logic [47:0] unit_axis(int pick);
      logic [15:0] p, n;
      p = 16'd16384;
      n = -16'sd16384;
      case (pick)
         0: return {p, 16'd0, 16'd0};
         1: return {16'd0, p, 16'd0};
         2: return {16'd0, 16'd0, p};
         3: return {n, 16'd0, 16'd0};
         4: return {16'd0, n, 16'd0};
         5: return {16'd0, 16'd0, n};
         6: return {16'd9459, 16'd9459, 16'd9459};
         default: return {16'd11585, -16'sd11585, 16'd0};
      endcase
   endfunction

   task automatic random_point;
      longint span, t, p[3];
      int kind;
      kind = $urandom_range(0, 99);
      span = rad + half + 64'sd262144;
      if (kind < 70) begin
         for (int i = 0; i < 3; i++) p[i] = ctr[i] + span_rand(span);
      end else if (kind < 85) begin
         t = span_rand(half + span);
         for (int i = 0; i < 3; i++) p[i] = ctr[i] + ((t * axc[i]) >>> UNIT_FB);
      end else begin
         for (int i = 0; i < 3; i++) p[i] = longint'($signed($urandom));
      end
      send_point(p[0], p[1], p[2]);
   endtask

   task automatic set_phase(int ph);
      logic [30:0] r31, h31;
      case (ph)
         1: begin
            for (int i = 0; i < 3; i++)
               write_reg(CSR_IDX_W'(REG_CENTER_X + i), 48'(span_rand(64'sd1048576)));
            write_reg(REG_AXIS, unit_axis(0));
            write_reg(REG_FALLBACK, unit_axis(2));
            write_reg(REG_RADIUS, 48'h20000);
            write_reg(REG_HALF_LEN, 48'h30000);
            write_reg(REG_MODE, 48'd0);
         end
         2: begin
            write_reg(REG_AXIS, unit_axis(4));
            write_reg(REG_RADIUS, 48'h8000);
            write_reg(REG_HALF_LEN, 48'h40000);
            write_reg(REG_MODE, 48'd1);
         end
         3: begin
            write_reg(REG_AXIS, unit_axis(2));
            write_reg(REG_RADIUS, 48'd0);
            write_reg(REG_HALF_LEN, 48'd0);
            write_reg(REG_MODE, 48'd2);
         end
         4: begin
            write_reg(REG_CENTER_X, 48'h7FFF_FFFF);
            write_reg(REG_CENTER_Y, 48'h8000_0000);
            write_reg(REG_CENTER_Z, 48'd0);
            write_reg(REG_RADIUS, 48'h7FFF_FFFF);
            write_reg(REG_HALF_LEN, 48'h7FFF_FFFF);
            write_reg(REG_MODE, 48'd3);
         end
         5: begin
            write_reg(REG_AXIS, 48'({$urandom, $urandom}));
            write_reg(REG_FALLBACK, 48'({$urandom, $urandom}));
            write_reg(REG_RADIUS, 48'($urandom_range(0, 16777215)));
            write_reg(REG_HALF_LEN, 48'($urandom_range(0, 16777215)));
            write_reg(REG_MODE, 48'($urandom_range(0, 3)));
         end
         6: begin
            write_reg(REG_CENTER_Y, 48'h1234);
            write_reg(REG_AXIS, unit_axis(6));
            write_reg(REG_FALLBACK, unit_axis(7));
            write_reg(REG_RADIUS, 48'h18000);
            write_reg(REG_HALF_LEN, 48'h10000);
            write_reg(REG_MODE, 48'd0);
         end
         7: begin
            write_reg(REG_AXIS, unit_axis(5));
            write_reg(REG_RADIUS, 48'h1000_0000);
            write_reg(REG_HALF_LEN, 48'h100);
            write_reg(REG_MODE, 48'd1);
         end
         default: begin
            for (int i = 0; i < 3; i++)
               write_reg(CSR_IDX_W'(REG_CENTER_X + i), ($urandom_range(0, 1) == 0) ?
                         48'($urandom) : 48'(span_rand(64'sd65536)));
            write_reg(REG_AXIS, ($urandom_range(0, 3) == 0) ?
                      48'({$urandom, $urandom}) : unit_axis($urandom_range(0, 7)));
            write_reg(REG_FALLBACK, unit_axis($urandom_range(0, 7)));
            r31 = 31'($urandom & ((32'd1 << $urandom_range(8, 31)) - 1));
            h31 = 31'($urandom & ((32'd1 << $urandom_range(8, 31)) - 1));
            write_reg(REG_RADIUS, 48'(r31));
            write_reg(REG_HALF_LEN, 48'(h31));
            write_reg(REG_MODE, 48'($urandom_range(0, 3)));
         end
      endcase
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      ctr = '{0, 0, 0};
      axc = '{0, 0, 16384};
      rad = 65536;
      half = 65536;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: on axis, caps, rim, side wall and field extremes
      send_point(0, 0, 0);
      send_point(0, 0, 'h10000);
      send_point(0, 0, -'h8000);
      send_point(0, 0, 'h30000);
      send_point('h8000, 0, 0);
      send_point(0, 'h18000, 0);
      send_point('h10000, 0, 'h10000);
      send_point('h20000, 0, -'h20000);
      send_point('h4000, 'h4000, 'hC000);
      send_point('h4000, -'h4000, -'hE000);
      send_point('h7FFF_FFFF, 'h7FFF_FFFF, 'h7FFF_FFFF);
      send_point(-'h8000_0000, -'h8000_0000, -'h8000_0000);
      send_point('h7FFF_FFFF, -'h8000_0000, 0);
      send_point(-1, -1, -1);
      send_point(0, 0, -'h8000_0000);
      drain();

      for (int ph = 1; ph <= LAST_PHASE; ph++) begin
         if (ph == LAST_PHASE) idling = 1'b0;
         set_phase(ph);
         csr_valid <= 1'b0;
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            random_point();
            if (ph == 5 && n == RAND_PER_PHASE / 2) begin
               drain();
            end
         end
         drain();
      end

      repeat (120) @(posedge clock);
      $display("covered %0d points over %0d register settings phases, %0d csr writes",
               points_sent, LAST_PHASE + 1, csr_writes);
      $display("checked %0d results including open ends, flipped sign and saturation",
               results_seen);
      if (failures == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
design/csd_pkg.sv
design/csd_proj.sv
design/csd_sqrt.sv
design/csd_div.sv
design/cylinder_signed_distance_unit.sv
sim/csd_checker.sv
sim/tb.sv
